// File: rtl/tlik_pkg.sv
// shared constants, types and tables for the two-link arm inverse kinematics unit
package tlik_pkg;

  localparam int COORD_W    = 16;
  localparam int LEN_W      = 15;
  localparam int TOL_W      = 12;
  localparam int ANGLE_W    = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LINK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_LINK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REACH_TOL   = 2'd2;

  localparam logic [LEN_W-1:0] LEN1_RST = 15'd4096;
  localparam logic [LEN_W-1:0] LEN2_RST = 15'd2458;
  localparam logic [TOL_W-1:0] TOL_RST  = 12'd1;

  // square root: one result bit per stage over a 64-bit radicand frame
  localparam int SQRT_STEPS = 32;
  localparam int SQ_W       = 64;

  // atan2 unit
  localparam int ATAN_IN_W    = 49;
  localparam int MAG_W        = 48;
  localparam int NORM_STEPS   = 6;
  localparam int CORDIC_STEPS = 20;
  localparam int CX_W         = 34;
  localparam int Z_W          = 22;
  localparam int ATAN_LAT     = 1 + NORM_STEPS + CORDIC_STEPS + 2;

  localparam logic signed [Z_W-1:0] FINE_HALF_PI = 22'sd524288;
  localparam logic [Z_W-2:0]        FINE_PI      = 21'd1048576;

  localparam logic signed [Z_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    22'sd262144, 22'sd154753, 22'sd81767, 22'sd41506, 22'sd20834,
    22'sd10427,  22'sd5215,   22'sd2608,  22'sd1304,  22'sd652,
    22'sd326,    22'sd163,    22'sd81,    22'sd41,    22'sd20,
    22'sd10,     22'sd5,      22'sd3,     22'sd1,     22'sd1
  };

  typedef struct packed {
    logic x_neg;
    logic y_neg;
    logic zero;
  } tlik_atan_flags_t;

  typedef struct packed {
    logic                      ok;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [31:0]        n;
    logic [30:0]               d;
  } tlik_side_t;

endpackage

// File: rtl/tlik_ifs.sv
// request channel interfaces for targets and joint solutions
interface tlik_in_if;
  import tlik_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] target_x;
  logic signed [COORD_W-1:0] target_y;
  modport source (output valid, target_x, target_y, input ready);
  modport sink (input valid, target_x, target_y, output ready);
endinterface

interface tlik_out_if;
  import tlik_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      reachable;
  logic signed [ANGLE_W-1:0] shoulder_angle_pos;
  logic signed [ANGLE_W-1:0] elbow_angle_pos;
  logic signed [ANGLE_W-1:0] shoulder_angle_neg;
  logic signed [ANGLE_W-1:0] elbow_angle_neg;
  modport source (output valid, reachable, shoulder_angle_pos, elbow_angle_pos,
                  shoulder_angle_neg, elbow_angle_neg, input ready);
  modport sink (input valid, reachable, shoulder_angle_pos, elbow_angle_pos,
                shoulder_angle_neg, elbow_angle_neg, output ready);
endinterface

// File: rtl/planar_two_link_inverse_kinematics_unit.sv
// Two-link planar arm inverse kinematics unit, fully pipelined.
//
// in_chan carries a target point (target_x, target_y), signed with 12 fraction
// bits. out_chan returns one result per target: the reachable flag and the
// shoulder and elbow angles of both elbow solutions (pi = 32768). Unreachable
// targets give zero angles. Link lengths and reach tolerance are written on
// the cfg port (cfg_we, cfg_index, cfg_data); the user must write them only
// while no request is in flight, as the block itself does not enforce it.
//
// The pipeline has 70 register stages: five of squaring and range checks,
// a 33-stage bit-per-stage square root, two product stages, the 29-stage
// atan2 units and the output register. It takes one request per cycle when
// out_chan does not stall; the pipeline is a single shift chain.
//
// Reset (synchronous, rst_n low) empties the pipeline and loads the default
// lengths 4096 and 2458 and tolerance 1. When the receiver holds ready low
// with a result waiting, the whole pipeline freezes and in_chan.ready drops;
// nothing is dropped or repeated, and bubbles flow out when valid is low.
module planar_two_link_inverse_kinematics_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  tlik_in_if.sink                            in_chan,
  tlik_out_if.source                         out_chan,
  input  logic                               cfg_we,
  input  logic [tlik_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tlik_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import tlik_pkg::*;

  localparam int PIPE_DEPTH = 6 + SQRT_STEPS + 2 + ATAN_LAT + 1;

  logic [LEN_W-1:0] l1_r, l2_r;
  logic [TOL_W-1:0] tol_r;
  logic [PIPE_DEPTH-1:0] val_r;
  logic adv;

  // stage 1
  logic signed [COORD_W-1:0] x1_r, y1_r;
  logic [30:0] xx1_r, yy1_r, l1sq1_r, l2sq1_r, d1_r;
  logic [33:0] hisq1_r;
  logic [29:0] losq1_r;
  logic        loen1_r;
  logic signed [31:0] xx_full, yy_full;
  logic [16:0] hi;
  logic [LEN_W-1:0] diff, lob;
  // stage 2
  logic signed [COORD_W-1:0] x2_r, y2_r;
  logic [31:0] dsq2_r, sumsq2_r;
  logic [33:0] hisq2_r;
  logic [29:0] losq2_r;
  logic        loen2_r;
  logic [30:0] d2_r;
  // stage 3
  logic signed [COORD_W-1:0] x3_r, y3_r;
  logic        ok3_r;
  logic signed [32:0] nraw3_r;
  logic [30:0] d3_r;
  // stage 4
  logic signed [COORD_W-1:0] x4_r, y4_r;
  logic        ok4_r;
  logic signed [31:0] n4_r;
  logic [30:0] nabs4_r, d4_r;
  logic signed [32:0] dpos, dneg;
  // stage 5
  logic [61:0] dd5_r, nn5_r;
  tlik_side_t  side5_r;
  // square root chain, index 0 holds the radicand
  logic [SQ_W-1:0] sq_v_r [SQRT_STEPS+1];
  logic [SQ_W-1:0] sq_q_r [SQRT_STEPS+1];
  tlik_side_t      side_r [SQRT_STEPS+1];
  // product stages
  logic [30:0] s_p1_r, s_p2_r;
  logic [45:0] pls1_r, pld1_r;
  logic signed [46:0] pln1_r;
  tlik_side_t  side_p1_r, side_p2_r;
  logic [45:0] psy2_r;
  logic signed [47:0] psx2_r;
  // atan outputs
  logic signed [ANGLE_W-1:0] phi, q2, psi;
  logic [ATAN_LAT-1:0] ok_d_r;
  // output register
  logic                      reach_o_r;
  logic signed [ANGLE_W-1:0] q1p_o_r, q2p_o_r, q1n_o_r, q2n_o_r;

  assign adv = !val_r[PIPE_DEPTH-1] || out_chan.ready;
  assign in_chan.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_r  <= LEN1_RST;
      l2_r  <= LEN2_RST;
      tol_r <= TOL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FIRST_LINK:  l1_r  <= cfg_data;
        CFG_SECOND_LINK: l2_r  <= cfg_data;
        CFG_REACH_TOL:   tol_r <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else if (adv) begin
      val_r <= {val_r[PIPE_DEPTH-2:0], in_chan.valid};
    end
  end

  assign xx_full = in_chan.target_x * in_chan.target_x;
  assign yy_full = in_chan.target_y * in_chan.target_y;
  assign hi      = 17'(l1_r) + 17'(l2_r) + 17'(tol_r);
  assign diff    = (l1_r > l2_r) ? l1_r - l2_r : l2_r - l1_r;
  assign lob     = diff - LEN_W'(tol_r);
  assign dpos    = $signed({2'b00, d3_r});
  assign dneg    = -dpos;

  always_ff @(posedge clk) begin
    if (adv) begin
      x1_r    <= in_chan.target_x;
      y1_r    <= in_chan.target_y;
      xx1_r   <= xx_full[30:0];
      yy1_r   <= yy_full[30:0];
      l1sq1_r <= 31'(l1_r * l1_r);
      l2sq1_r <= 31'(l2_r * l2_r);
      d1_r    <= 31'({l1_r, 1'b0} * l2_r);
      hisq1_r <= 34'(hi * hi);
      losq1_r <= 30'(lob * lob);
      loen1_r <= diff > LEN_W'(tol_r);

      x2_r     <= x1_r;
      y2_r     <= y1_r;
      dsq2_r   <= 32'(xx1_r) + 32'(yy1_r);
      sumsq2_r <= 32'(l1sq1_r) + 32'(l2sq1_r);
      hisq2_r  <= hisq1_r;
      losq2_r  <= losq1_r;
      loen2_r  <= loen1_r;
      d2_r     <= d1_r;

      x3_r    <= x2_r;
      y3_r    <= y2_r;
      ok3_r   <= !(34'(dsq2_r) > hisq2_r) && !(loen2_r && (dsq2_r < 32'(losq2_r)));
      nraw3_r <= $signed({1'b0, dsq2_r}) - $signed({1'b0, sumsq2_r});
      d3_r    <= d2_r;

      // clamp the cosine numerator to [-d, d]
      x4_r  <= x3_r;
      y4_r  <= y3_r;
      ok4_r <= ok3_r;
      d4_r  <= d3_r;
      if (nraw3_r > dpos) begin
        n4_r    <= dpos[31:0];
        nabs4_r <= d3_r;
      end else if (nraw3_r < dneg) begin
        n4_r    <= dneg[31:0];
        nabs4_r <= d3_r;
      end else begin
        n4_r    <= nraw3_r[31:0];
        nabs4_r <= nraw3_r[32] ? 31'(-nraw3_r) : nraw3_r[30:0];
      end

      dd5_r   <= d4_r * d4_r;
      nn5_r   <= nabs4_r * nabs4_r;
      side5_r <= '{ok: ok4_r, x: x4_r, y: y4_r, n: n4_r, d: d4_r};

      sq_v_r[0] <= SQ_W'(dd5_r - nn5_r);
      sq_q_r[0] <= '0;
      side_r[0] <= side5_r;
    end
  end

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - j));
    logic [SQ_W-1:0] trial;
    assign trial = sq_q_r[j] + BIT;
    always_ff @(posedge clk) begin
      if (adv) begin
        side_r[j+1] <= side_r[j];
        if (sq_v_r[j] >= trial) begin
          sq_v_r[j+1] <= sq_v_r[j] - trial;
          sq_q_r[j+1] <= (sq_q_r[j] >> 1) + BIT;
        end else begin
          sq_v_r[j+1] <= sq_v_r[j];
          sq_q_r[j+1] <= sq_q_r[j] >> 1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_p1_r    <= sq_q_r[SQRT_STEPS][30:0];
      side_p1_r <= side_r[SQRT_STEPS];
      pls1_r    <= l2_r * sq_q_r[SQRT_STEPS][30:0];
      pld1_r    <= l1_r * side_r[SQRT_STEPS].d;
      pln1_r    <= $signed({1'b0, l2_r}) * side_r[SQRT_STEPS].n;

      s_p2_r    <= s_p1_r;
      side_p2_r <= side_p1_r;
      psy2_r    <= pls1_r;
      psx2_r    <= $signed({2'b00, pld1_r}) + 48'(pln1_r);

      ok_d_r    <= {ok_d_r[ATAN_LAT-2:0], side_p2_r.ok};

      reach_o_r <= ok_d_r[ATAN_LAT-1];
      if (ok_d_r[ATAN_LAT-1]) begin
        q1p_o_r <= phi - psi;
        q2p_o_r <= q2;
        q1n_o_r <= phi + psi;
        q2n_o_r <= -q2;
      end else begin
        q1p_o_r <= '0;
        q2p_o_r <= '0;
        q1n_o_r <= '0;
        q2n_o_r <= '0;
      end
    end
  end

  tlik_atan2 u_phi (
    .clk   (clk),
    .en    (adv),
    .y_in  (ATAN_IN_W'(side_p2_r.y)),
    .x_in  (ATAN_IN_W'(side_p2_r.x)),
    .angle (phi)
  );

  tlik_atan2 u_elbow (
    .clk   (clk),
    .en    (adv),
    .y_in  ($signed({18'b0, s_p2_r})),
    .x_in  (ATAN_IN_W'(side_p2_r.n)),
    .angle (q2)
  );

  tlik_atan2 u_psi (
    .clk   (clk),
    .en    (adv),
    .y_in  ($signed({3'b000, psy2_r})),
    .x_in  (ATAN_IN_W'(psx2_r)),
    .angle (psi)
  );

  assign out_chan.valid              = val_r[PIPE_DEPTH-1];
  assign out_chan.reachable          = reach_o_r;
  assign out_chan.shoulder_angle_pos = q1p_o_r;
  assign out_chan.elbow_angle_pos    = q2p_o_r;
  assign out_chan.shoulder_angle_neg = q1n_o_r;
  assign out_chan.elbow_angle_neg    = q2n_o_r;

endmodule

// File: rtl/tlik_atan2.sv
// pipelined atan2: normalize, 20-step vectoring cordic, quadrant fixup and rounding
module tlik_atan2 (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [tlik_pkg::ATAN_IN_W-1:0] y_in,
  input  logic signed [tlik_pkg::ATAN_IN_W-1:0] x_in,
  output logic signed [tlik_pkg::ANGLE_W-1:0]   angle
);
  import tlik_pkg::*;

  logic [ATAN_IN_W-1:0] ax_abs, ay_abs;
  logic [MAG_W-1:0]     nm_ax_r [NORM_STEPS+1];
  logic [MAG_W-1:0]     nm_ay_r [NORM_STEPS+1];
  logic [MAG_W-1:0]     nm_big_r [NORM_STEPS+1];
  tlik_atan_flags_t     fl_r [ATAN_LAT-1];
  logic signed [CX_W-1:0] cx_r [CORDIC_STEPS];
  logic signed [CX_W-1:0] cy_r [CORDIC_STEPS];
  logic signed [Z_W-1:0]  z_r  [CORDIC_STEPS];
  logic [Z_W-2:0]         zm_r;
  logic [Z_W-2:0]         zm_nxt;
  logic signed [Z_W-1:0]  zc;
  logic [Z_W-1:0]         rnd;
  logic signed [ANGLE_W-1:0] angle_r;

  assign ax_abs = x_in[ATAN_IN_W-1] ? ATAN_IN_W'(-x_in) : x_in;
  assign ay_abs = y_in[ATAN_IN_W-1] ? ATAN_IN_W'(-y_in) : y_in;

  always_ff @(posedge clk) begin
    if (en) begin
      nm_ax_r[0]  <= ax_abs[MAG_W-1:0];
      nm_ay_r[0]  <= ay_abs[MAG_W-1:0];
      nm_big_r[0] <= (ax_abs > ay_abs) ? ax_abs[MAG_W-1:0] : ay_abs[MAG_W-1:0];
      fl_r[0]     <= '{x_neg: x_in[ATAN_IN_W-1], y_neg: y_in[ATAN_IN_W-1],
                       zero: (ax_abs == '0) && (ay_abs == '0)};
      for (int k = 1; k < ATAN_LAT-1; k++) begin
        fl_r[k] <= fl_r[k-1];
      end
    end
  end

  // shift left until the leading one of the larger magnitude reaches the top
  for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
    localparam int SH = 32 >> j;
    logic hit;
    assign hit = (nm_big_r[j][MAG_W-1 -: SH] == '0);
    always_ff @(posedge clk) begin
      if (en) begin
        nm_ax_r[j+1]  <= hit ? (nm_ax_r[j] << SH) : nm_ax_r[j];
        nm_ay_r[j+1]  <= hit ? (nm_ay_r[j] << SH) : nm_ay_r[j];
        nm_big_r[j+1] <= hit ? (nm_big_r[j] << SH) : nm_big_r[j];
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    logic signed [CX_W-1:0] cx_in, cy_in;
    logic signed [Z_W-1:0]  z_in;
    if (i == 0) begin : g_first
      // top 30 bits put the larger magnitude in [2^29, 2^30)
      assign cx_in = $signed({4'b0000, nm_ax_r[NORM_STEPS][MAG_W-1 -: 30]});
      assign cy_in = $signed({4'b0000, nm_ay_r[NORM_STEPS][MAG_W-1 -: 30]});
      assign z_in  = '0;
    end else begin : g_rest
      assign cx_in = cx_r[i-1];
      assign cy_in = cy_r[i-1];
      assign z_in  = z_r[i-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (!cy_in[CX_W-1]) begin
          cx_r[i] <= cx_in + (cy_in >>> i);
          cy_r[i] <= cy_in - (cx_in >>> i);
          z_r[i]  <= z_in + ATAN_TAB[i];
        end else begin
          cx_r[i] <= cx_in - (cy_in >>> i);
          cy_r[i] <= cy_in + (cx_in >>> i);
          z_r[i]  <= z_in - ATAN_TAB[i];
        end
      end
    end
  end

  always_comb begin
    zc = z_r[CORDIC_STEPS-1];
    if (zc < 0) zc = '0;
    if (zc > FINE_HALF_PI) zc = FINE_HALF_PI;
    zm_nxt = fl_r[ATAN_LAT-3].x_neg ? FINE_PI - zc[Z_W-2:0] : zc[Z_W-2:0];
  end

  assign rnd = ({1'b0, zm_r} + Z_W'(16)) >> 5;

  always_ff @(posedge clk) begin
    if (en) begin
      zm_r <= zm_nxt;
      if (fl_r[ATAN_LAT-2].zero) begin
        angle_r <= '0;
      end else if (fl_r[ATAN_LAT-2].y_neg) begin
        angle_r <= -$signed(rnd[ANGLE_W-1:0]);
      end else begin
        angle_r <= $signed(rnd[ANGLE_W-1:0]);
      end
    end
  end

  assign angle = angle_r;

endmodule

// File: rtl/tlik_chk.sv
// port-level checks for the inverse kinematics unit and their bind
module tlik_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic                               reachable,
  input logic signed [tlik_pkg::ANGLE_W-1:0] shoulder_angle_pos,
  input logic signed [tlik_pkg::ANGLE_W-1:0] elbow_angle_pos,
  input logic signed [tlik_pkg::ANGLE_W-1:0] shoulder_angle_neg,
  input logic signed [tlik_pkg::ANGLE_W-1:0] elbow_angle_neg
);
  import tlik_pkg::*;

  // a held result keeps its reachable flag and positive-solution angles
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(elbow_angle_pos) &&
    $stable(shoulder_angle_pos) && $stable(reachable))
    else $error("held result changed");

  // unreachable targets carry zero angles
  a_unreach_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !reachable |-> shoulder_angle_pos == '0 && elbow_angle_pos == '0 &&
    shoulder_angle_neg == '0 && elbow_angle_neg == '0)
    else $error("unreachable result with nonzero angle");

  // the two elbow solutions mirror each other
  a_elbow_mirror: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> elbow_angle_neg == -elbow_angle_pos)
    else $error("elbow solutions not mirrored");

  // positive elbow lies in [0, pi]
  a_elbow_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !elbow_angle_pos[ANGLE_W-1] && elbow_angle_pos <= 17'sd32768)
    else $error("elbow angle out of range");

  // with no result waiting the unit takes requests
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("stalled with empty output");

endmodule

bind planar_two_link_inverse_kinematics_unit tlik_chk u_tlik_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_chan.ready),
  .out_valid          (out_chan.valid),
  .out_ready          (out_chan.ready),
  .reachable          (out_chan.reachable),
  .shoulder_angle_pos (out_chan.shoulder_angle_pos),
  .elbow_angle_pos    (out_chan.elbow_angle_pos),
  .shoulder_angle_neg (out_chan.shoulder_angle_neg),
  .elbow_angle_neg    (out_chan.elbow_angle_neg)
);
